// ----- src/rcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared widths, codes, reset values and channel decoding for the radio
// channel conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

  // Sample and channel geometry
  localparam int SAMPLE_BITS    = 11;
  localparam int CHANNEL_COUNT  = 16;
  localparam int STICK_COUNT    = 4;
  localparam int CH_BITS        = $clog2(CHANNEL_COUNT);
  localparam int STICK_IDX_BITS = $clog2(STICK_COUNT);
  localparam int PACK_BITS      = STICK_COUNT * SAMPLE_BITS;

  // Output value and switch threshold widths
  localparam int VALUE_BITS = 16;
  localparam int THR_BITS   = 11;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = PACK_BITS;

  // Stick arithmetic: product of the offset and the output span, then a
  // divider that retires RADIX_BITS quotient bits per cycle.
  localparam int PROD_BITS  = SAMPLE_BITS + VALUE_BITS;
  localparam int RADIX_BITS = 2;
  localparam int DIV_STEPS  = (PROD_BITS + RADIX_BITS - 1) / RADIX_BITS;
  localparam int DIV_BITS   = DIV_STEPS * RADIX_BITS;
  localparam int CNT_BITS   = $clog2(DIV_STEPS);
  localparam int ADJ_BITS   = DIV_BITS + 2;

  // Reset values of the configuration registers
  localparam logic signed [VALUE_BITS-1:0] SCALE_LOW_RST  = -16'sd255;
  localparam logic signed [VALUE_BITS-1:0] SCALE_HIGH_RST = 16'sd255;
  localparam logic [THR_BITS-1:0]          THR_LOW_RST    = 11'd200;
  localparam logic [THR_BITS-1:0]          THR_HIGH_RST   = 11'd1100;

  // Saturation limits of the output value
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_STICK_MIN  = 3'd0,
    CFG_STICK_MAX  = 3'd1,
    CFG_INVERT     = 3'd2,
    CFG_SCALE_LOW  = 3'd3,
    CFG_SCALE_HIGH = 3'd4,
    CFG_SW_LOW     = 3'd5,
    CFG_SW_HIGH    = 3'd6
  } cfg_reg_e;

  // Conditioning rule of a channel
  typedef enum logic [1:0] {
    CLS_STICK,
    CLS_SWITCH2,
    CLS_SWITCH3,
    CLS_PASS
  } ch_class_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_DIV,
    ST_ADJUST,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mult;
    logic div_step;
    logic adjust;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_stick;
  } dp_status_t;

  // Maps a channel number to its conditioning rule.
  function automatic ch_class_e channel_class(input logic [CH_BITS-1:0] ch);
    ch_class_e cls;
    if (ch < CH_BITS'(STICK_COUNT)) begin
      cls = CLS_STICK;
    end else if (ch inside {CH_BITS'(4), CH_BITS'(6), CH_BITS'(9)}) begin
      cls = CLS_SWITCH2;
    end else if (ch inside {CH_BITS'(5), CH_BITS'(7), CH_BITS'(8)}) begin
      cls = CLS_SWITCH3;
    end else begin
      cls = CLS_PASS;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ----- src/rcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcc_ctrl
// Sequencing state machine: captures a transaction, steps the datapath
// through multiply, then divide and adjust for a stick sample, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  rcc_pkg::dp_status_t status_i,
  output rcc_pkg::ctrl_cmd_t  cmd_o
);
  import rcc_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;
  logic                div_last;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;
  assign div_last = (cnt_q == CNT_BITS'(DIV_STEPS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MULT;
      end
      ST_MULT: begin
        state_d = status_i.is_stick ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (div_last) state_d = ST_ADJUST;
      end
      ST_ADJUST: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd_o          = '0;
    in_ready_o     = (state_q == ST_IDLE);
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mult     = (state_q == ST_MULT);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.adjust   = (state_q == ST_ADJUST);
    cmd_o.emit     = (state_q == ST_EMIT) && out_free;
  end

  // Divider step count and output valid flag
  always_comb begin
    cnt_d       = (state_q == ST_DIV) ? cnt_q + CNT_BITS'(1) : '0;
    out_valid_d = cmd_o.emit || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/rcc_datapath.sv -----
// ----------------------------------------------------------------------------
// rcc_datapath
// Configuration registers, per-channel history, stick scaling arithmetic
// with a radix-4 restoring divider, switch decoding and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_datapath (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_valid_i,
  input  wire  [rcc_pkg::CFG_INDEX_BITS-1:0]      cfg_index_i,
  input  wire  [rcc_pkg::CFG_DATA_BITS-1:0]       cfg_data_i,
  input  wire  [rcc_pkg::CH_BITS-1:0]             channel_index_i,
  input  wire  [rcc_pkg::SAMPLE_BITS-1:0]         raw_value_i,
  input  wire                                     fail_safe_i,
  input  rcc_pkg::ctrl_cmd_t                      cmd_i,
  output rcc_pkg::dp_status_t                     status_o,
  output logic signed [rcc_pkg::VALUE_BITS-1:0]   conditioned_value_o,
  output logic                                    rising_edge_o,
  output logic                                    falling_edge_o,
  output logic                                    zero_span_o
);
  import rcc_pkg::*;

  // Configuration registers
  logic [STICK_COUNT-1:0][SAMPLE_BITS-1:0] stick_min_q, stick_max_q;
  logic [STICK_COUNT-1:0]                  invert_q;
  logic signed [VALUE_BITS-1:0]            scale_low_q, scale_high_q;
  logic [THR_BITS-1:0]                     thr_low_q, thr_high_q;

  // Captured transaction
  logic [CH_BITS-1:0]     ch_q;
  logic [SAMPLE_BITS-1:0] raw_q;
  logic                   fs_q;

  // History of stored results
  logic [VALUE_BITS-1:0] prev_q [CHANNEL_COUNT];

  // Arithmetic registers
  logic [DIV_BITS-1:0]          quo_q, quo_d;
  logic [SAMPLE_BITS-1:0]       rem_q, rem_d;
  logic [SAMPLE_BITS-1:0]       den_q;
  logic                         neg_q;
  logic                         zspan_q;
  logic signed [ADJ_BITS-1:0]   v_q;

  // Output register
  logic signed [VALUE_BITS-1:0] value_q;
  logic                         rising_q, falling_q, zspan_out_q;

  // Combinational terms
  ch_class_e                    cls;
  logic [STICK_IDX_BITS-1:0]    idx;
  logic [SAMPLE_BITS-1:0]       lo, hi;
  logic signed [SAMPLE_BITS:0]  diff, diff_neg, den, den_neg;
  logic signed [VALUE_BITS:0]   span, span_neg;
  logic [SAMPLE_BITS-1:0]       diff_mag, den_mag;
  logic [VALUE_BITS-1:0]        span_mag;
  logic [PROD_BITS-1:0]         prod;
  logic signed [DIV_BITS:0]     q_s;
  logic signed [ADJ_BITS-1:0]   v_d, top_e, bot_e, clamp_hi, clamp_lo;
  logic signed [VALUE_BITS-1:0] clamp_v, inv_v, stick_v, val;
  logic [VALUE_BITS-1:0]        prev, raw_e, thr_low_e, thr_high_e;
  logic                         keep;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stick_min_q  <= '0;
      stick_max_q  <= '1;
      invert_q     <= '0;
      scale_low_q  <= SCALE_LOW_RST;
      scale_high_q <= SCALE_HIGH_RST;
      thr_low_q    <= THR_LOW_RST;
      thr_high_q   <= THR_HIGH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_STICK_MIN:  stick_min_q  <= cfg_data_i[PACK_BITS-1:0];
        CFG_STICK_MAX:  stick_max_q  <= cfg_data_i[PACK_BITS-1:0];
        CFG_INVERT:     invert_q     <= cfg_data_i[STICK_COUNT-1:0];
        CFG_SCALE_LOW:  scale_low_q  <= $signed(cfg_data_i[VALUE_BITS-1:0]);
        CFG_SCALE_HIGH: scale_high_q <= $signed(cfg_data_i[VALUE_BITS-1:0]);
        CFG_SW_LOW:     thr_low_q    <= cfg_data_i[THR_BITS-1:0];
        CFG_SW_HIGH:    thr_high_q   <= cfg_data_i[THR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Channel decode and stick calibration selection
  assign cls               = channel_class(ch_q);
  assign status_o.is_stick = (cls == CLS_STICK);
  assign idx               = ch_q[STICK_IDX_BITS-1:0];
  assign lo                = stick_min_q[idx];
  assign hi                = stick_max_q[idx];

  // Offset, output span and calibrated span as sign and magnitude, then
  // the product of the two magnitudes.
  always_comb begin
    diff     = $signed({1'b0, raw_q}) - $signed({1'b0, lo});
    diff_neg = -diff;
    den      = $signed({1'b0, hi}) - $signed({1'b0, lo});
    den_neg  = -den;
    span     = $signed({scale_high_q[VALUE_BITS-1], scale_high_q})
             - $signed({scale_low_q[VALUE_BITS-1], scale_low_q});
    span_neg = -span;
    diff_mag = diff[SAMPLE_BITS] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
    den_mag  = den[SAMPLE_BITS] ? den_neg[SAMPLE_BITS-1:0] : den[SAMPLE_BITS-1:0];
    span_mag = span[VALUE_BITS] ? span_neg[VALUE_BITS-1:0] : span[VALUE_BITS-1:0];
    prod     = PROD_BITS'(diff_mag) * PROD_BITS'(span_mag);
  end

  // Two restoring division steps per cycle; the dividend shifts out of the
  // top of quo while quotient bits shift in at the bottom.
  always_comb begin
    logic [SAMPLE_BITS:0] trial;
    logic [DIV_BITS-1:0]  qv;
    logic [SAMPLE_BITS-1:0] r;
    r  = rem_q;
    qv = quo_q;
    for (int k = 0; k < RADIX_BITS; k++) begin
      trial = {r, qv[DIV_BITS-1]};
      qv    = {qv[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        qv[0] = 1'b1;
      end
      r = trial[SAMPLE_BITS-1:0];
    end
    rem_d = r;
    quo_d = qv;
  end

  // Signed quotient plus the scale floor
  always_comb begin
    q_s = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    v_d = ADJ_BITS'(q_s) + ADJ_BITS'(scale_low_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q  <= channel_index_i;
      raw_q <= raw_value_i;
      fs_q  <= fail_safe_i;
    end
    if (cmd_i.mult) begin
      quo_q   <= DIV_BITS'(prod);
      rem_q   <= '0;
      den_q   <= den_mag;
      neg_q   <= diff[SAMPLE_BITS] ^ den[SAMPLE_BITS] ^ span[VALUE_BITS];
      zspan_q <= (lo == hi) && (cls == CLS_STICK);
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.adjust) begin
      v_q <= zspan_q ? ADJ_BITS'(scale_low_q) : v_d;
    end
  end

  // Stick result: clamp to the scale, optional saturating negation, and
  // zero during failsafe.
  always_comb begin
    top_e    = ADJ_BITS'(scale_high_q);
    bot_e    = ADJ_BITS'(scale_low_q);
    clamp_hi = (v_q > top_e) ? top_e : v_q;
    clamp_lo = (clamp_hi < bot_e) ? bot_e : clamp_hi;
    clamp_v  = clamp_lo[VALUE_BITS-1:0];
    inv_v    = (clamp_v == VALUE_MIN) ? VALUE_MAX : -clamp_v;
    if (fs_q) begin
      stick_v = '0;
    end else begin
      stick_v = invert_q[idx] ? inv_v : clamp_v;
    end
  end

  // Result selection by channel rule
  always_comb begin
    prev       = prev_q[ch_q];
    raw_e      = VALUE_BITS'(raw_q);
    thr_low_e  = VALUE_BITS'(thr_low_q);
    thr_high_e = VALUE_BITS'(thr_high_q);
    keep       = 1'b0;
    case (cls)
      CLS_STICK: begin
        val = stick_v;
      end
      CLS_SWITCH2: begin
        if (raw_e > thr_high_e) begin
          val = VALUE_BITS'(1);
        end else if (raw_e < thr_low_e) begin
          val = '0;
        end else begin
          // Middle zone toggles against the stored value and keeps it.
          val  = (prev == '0) ? VALUE_BITS'(1) : '0;
          keep = 1'b1;
        end
      end
      CLS_SWITCH3: begin
        if (raw_e > thr_high_e) begin
          val = VALUE_BITS'(2);
        end else if (raw_e > thr_low_e) begin
          val = VALUE_BITS'(1);
        end else begin
          val = '0;
        end
      end
      default: begin
        val = $signed(raw_e);
      end
    endcase
  end

  // History update when a result is delivered to the output register, unless the result keeps the stored value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        prev_q[i] <= '0;
      end
    end else if (cmd_i.emit && !keep) begin
      prev_q[ch_q] <= val;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      value_q     <= val;
      rising_q    <= (prev == '0) && (val != '0);
      falling_q   <= (prev != '0) && (val == '0);
      zspan_out_q <= zspan_q;
    end
  end

  assign conditioned_value_o = value_q;
  assign rising_edge_o       = rising_q;
  assign falling_edge_o      = falling_q;
  assign zero_span_o         = zspan_out_q;

endmodule

`default_nettype wire

// ----- src/rc_channel_conditioner.sv -----
// ----------------------------------------------------------------------------
// rc_channel_conditioner
// Conditions one raw receiver channel sample per transaction: stick scaling,
// switch decoding or passthrough, with edge flags against stored history.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time. A stick sample (channels 0 to
// 3) goes from acceptance through the multiply, the divider that retires two
// quotient bits per cycle, the addition of the scale floor and the load of
// the result register, which waits while the output register holds a result
// that is not being taken, and back to idle before the next sample can be
// accepted. Switch and passthrough channels skip the divider and the scale
// floor. A finished result waits in the output register while the next sample
// is already taken in. Configuration writes complete in the cycle they are
// offered and must be made only while the block is idle.
`default_nettype none

module rc_channel_conditioner (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Configuration write channel
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [rcc_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  wire  [rcc_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  // Input channel
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  [rcc_pkg::CH_BITS-1:0]           channel_index_i,
  input  wire  [rcc_pkg::SAMPLE_BITS-1:0]       raw_value_i,
  input  wire                                   fail_safe_i,
  // Output channel
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [rcc_pkg::VALUE_BITS-1:0] conditioned_value_o,
  output logic                                  rising_edge_o,
  output logic                                  falling_edge_o,
  output logic                                  zero_span_o
);
  import rcc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register writes are always taken at once.
  assign cfg_ready_o = 1'b1;

  // Sequencer
  rcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic, history and result register
  rcc_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .channel_index_i     (channel_index_i),
    .raw_value_i         (raw_value_i),
    .fail_safe_i         (fail_safe_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .conditioned_value_o (conditioned_value_o),
    .rising_edge_o       (rising_edge_o),
    .falling_edge_o      (falling_edge_o),
    .zero_span_o         (zero_span_o)
  );

endmodule

`default_nettype wire

// ----- src/rcc_checker.sv -----
// ----------------------------------------------------------------------------
// rcc_checker
// Port-level checks for the channel conditioner, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_checker (
  input wire                                   clk_i,
  input wire                                   rst_ni,
  input wire                                   in_valid_i,
  input wire                                   in_ready_o,
  input wire                                   out_valid_o,
  input wire                                   out_ready_i,
  input wire signed [rcc_pkg::VALUE_BITS-1:0]  conditioned_value_o,
  input wire                                   rising_edge_o,
  input wire                                   falling_edge_o
);

  // A stalled result transaction keeps its valid and its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(conditioned_value_o))
    else $error("stalled result changed");

  // The block works on one sample at a time, so it is busy right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sample taken while previous still in work");

  // Both edge flags at once cannot happen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rising_edge_o && falling_edge_o))
    else $error("rising and falling flags both set");

  // An edge flag agrees with the value it reports.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rising_edge_o || falling_edge_o)
      |-> (rising_edge_o == (conditioned_value_o != '0)))
    else $error("edge flag disagrees with value");

endmodule

bind rc_channel_conditioner rcc_checker u_rcc_checker (.*);

`default_nettype wire

// ----- dv/rcc_result_checker.sv -----
// ----------------------------------------------------------------------------
// rcc_result_checker
// Watches the configuration, input and output channels of the radio channel
// conditioner. It keeps its own copy of the registers and channel history,
// predicts the result of every accepted sample, and compares each result
// transaction field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_result_checker
  import rcc_pkg::*;
(
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Configuration write channel
  input  wire                          cfg_valid_i,
  input  wire                          cfg_ready_i,
  input  wire  [CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  wire  [CFG_DATA_BITS-1:0]     cfg_data_i,
  // Input channel
  input  wire                          in_valid_i,
  input  wire                          in_ready_i,
  input  wire  [CH_BITS-1:0]           channel_index_i,
  input  wire  [SAMPLE_BITS-1:0]       raw_value_i,
  input  wire                          fail_safe_i,
  // Output channel
  input  wire                          out_valid_i,
  input  wire                          out_ready_i,
  input  wire  signed [VALUE_BITS-1:0] conditioned_value_i,
  input  wire                          rising_edge_i,
  input  wire                          falling_edge_i,
  input  wire                          zero_span_i,
  // Status towards the testbench top
  output int unsigned                  mismatch_count_o,
  output int unsigned                  results_waiting_o
);

  // One conditioned result as it appears on the output channel.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         rise;
    logic                         fall;
    logic                         span_zero;
  } conditioned_t;

  // Shadow copy of the configuration registers.
  logic [PACK_BITS-1:0]          cal_min;
  logic [PACK_BITS-1:0]          cal_max;
  logic [STICK_COUNT-1:0]        invert;
  logic signed [VALUE_BITS-1:0]  scale_bot;
  logic signed [VALUE_BITS-1:0]  scale_top;
  logic [THR_BITS-1:0]           thr_lo;
  logic [THR_BITS-1:0]           thr_hi;

  // Last stored value of every channel, and the results still owed.
  logic [VALUE_BITS-1:0]         history [CHANNEL_COUNT];
  conditioned_t                  expected_q [$];
  int unsigned                   mismatches;

  // Maps a stick sample from its calibrated span onto the output scale, with
  // the quotient truncated toward zero, then clamps, inverts and saturates.
  function automatic logic signed [VALUE_BITS-1:0] scale_stick(
    input  int unsigned             stick,
    input  logic [SAMPLE_BITS-1:0]  raw,
    input  logic                    failsafe,
    output logic                    span_zero
  );
    longint lo;
    longint hi;
    longint top;
    longint bot;
    longint v;
    lo        = longint'(cal_min[stick*SAMPLE_BITS +: SAMPLE_BITS]);
    hi        = longint'(cal_max[stick*SAMPLE_BITS +: SAMPLE_BITS]);
    top       = longint'(scale_top);
    bot       = longint'(scale_bot);
    span_zero = (lo == hi);
    // The span flag survives failsafe even though the value is forced to 0.
    if (failsafe) begin
      return '0;
    end
    if (span_zero) begin
      v = bot;
    end else begin
      v = (longint'(raw) - lo) * (top - bot) / (hi - lo) + bot;
    end
    // With a crossed scale the floor is applied last and wins.
    if (v > top) begin
      v = top;
    end
    if (v < bot) begin
      v = bot;
    end
    // Negating the most negative value saturates at the top of the range.
    if (invert[stick]) begin
      v = -v;
      if (v > 32767) begin
        v = 32767;
      end
    end
    return VALUE_BITS'(v);
  endfunction

  // Works out the result of one sample and updates the channel history.
  function automatic conditioned_t predict_sample(
    input logic [CH_BITS-1:0]      ch,
    input logic [SAMPLE_BITS-1:0]  raw,
    input logic                    failsafe
  );
    conditioned_t          res;
    logic [VALUE_BITS-1:0] prev;
    logic                  hold;
    logic                  zs;
    prev = history[ch];
    hold = 1'b0;
    zs   = 1'b0;
    case (ch)
      0, 1, 2, 3: begin
        res.value = scale_stick(ch, raw, failsafe, zs);
      end
      4, 6, 9: begin
        if (raw > thr_hi) begin
          res.value = 1;
        end else if (raw < thr_lo) begin
          res.value = 0;
        end else begin
          // Middle zone: report the inverse of the stored value but keep it.
          res.value = (prev == 0) ? 1 : 0;
          hold      = 1'b1;
        end
      end
      5, 7, 8: begin
        if (raw > thr_hi) begin
          res.value = 2;
        end else if (raw > thr_lo) begin
          res.value = 1;
        end else begin
          res.value = 0;
        end
      end
      default: begin
        res.value = VALUE_BITS'(raw);
      end
    endcase
    res.span_zero = zs;
    res.rise      = (prev == 0) && (res.value != 0);
    res.fall      = (prev != 0) && (res.value == 0);
    if (!hold) begin
      history[ch] = res.value;
    end
    return res;
  endfunction

  // Result transactions are checked before new samples are predicted, so a
  // result can never be matched against a prediction made at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    conditioned_t got;
    conditioned_t want;
    if (!rst_ni) begin
      cal_min   = '0;
      cal_max   = '1;
      invert    = '0;
      scale_bot = -16'sd255;
      scale_top = 16'sd255;
      thr_lo    = 11'd200;
      thr_hi    = 11'd1100;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        history[c] = '0;
      end
      expected_q.delete();
      mismatches = 0;
      mismatch_count_o  <= 0;
      results_waiting_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.value     = conditioned_value_i;
        got.rise      = rising_edge_i;
        got.fall      = falling_edge_i;
        got.span_zero = zero_span_i;
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected: conditioned_value %0d",
                 got.value);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value) begin
            $error("conditioned_value: expected %0d, actual %0d", want.value, got.value);
            mismatches++;
          end
          if (got.rise !== want.rise) begin
            $error("rising_edge: expected %0b, actual %0b", want.rise, got.rise);
            mismatches++;
          end
          if (got.fall !== want.fall) begin
            $error("falling_edge: expected %0b, actual %0b", want.fall, got.fall);
            mismatches++;
          end
          if (got.span_zero !== want.span_zero) begin
            $error("zero_span: expected %0b, actual %0b", want.span_zero, got.span_zero);
            mismatches++;
          end
        end
      end

      // Register writes; stray bits above each register's width are dropped.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_STICK_MIN:  cal_min   = cfg_data_i[PACK_BITS-1:0];
          CFG_STICK_MAX:  cal_max   = cfg_data_i[PACK_BITS-1:0];
          CFG_INVERT:     invert    = cfg_data_i[STICK_COUNT-1:0];
          CFG_SCALE_LOW:  scale_bot = cfg_data_i[VALUE_BITS-1:0];
          CFG_SCALE_HIGH: scale_top = cfg_data_i[VALUE_BITS-1:0];
          CFG_SW_LOW:     thr_lo    = cfg_data_i[THR_BITS-1:0];
          CFG_SW_HIGH:    thr_hi    = cfg_data_i[THR_BITS-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(predict_sample(channel_index_i, raw_value_i, fail_safe_i));
      end

      mismatch_count_o  <= mismatches;
      results_waiting_o <= expected_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_rc_channel_conditioner.sv -----
// ----------------------------------------------------------------------------
// tb_rc_channel_conditioner
// Drives the radio channel conditioner with a directed set of samples at the
// register extremes and then with randomised phases, each under a fresh
// configuration, while both channels idle at random. Results are checked by
// rcc_result_checker; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rc_channel_conditioner;
  import rcc_pkg::*;

  // Index that decodes to no register; a write to it must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 3'd7;

  localparam int unsigned RANDOM_PHASES   = 7;
  localparam int unsigned PHASE_ITEMS     = 150;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 24;
  localparam int unsigned DRAIN_GUARD     = 50000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0]     cfg_index_i;
  logic [CFG_DATA_BITS-1:0]      cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [CH_BITS-1:0]            channel_index_i;
  logic [SAMPLE_BITS-1:0]        raw_value_i;
  logic                          fail_safe_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [VALUE_BITS-1:0]  conditioned_value_o;
  logic                          rising_edge_o;
  logic                          falling_edge_o;
  logic                          zero_span_o;

  int unsigned                   mismatch_count;
  int unsigned                   results_waiting;

  // Current calibration and thresholds, used to aim samples at the edges.
  logic [SAMPLE_BITS-1:0]        cal_lo [STICK_COUNT];
  logic [SAMPLE_BITS-1:0]        cal_hi [STICK_COUNT];
  logic [THR_BITS-1:0]           sw_low_cur;
  logic [THR_BITS-1:0]           sw_high_cur;

  // Burst mode removes the sender's gaps; hold-off requests go to the receiver.
  logic                          burst;
  int unsigned                   hold_wanted;

  rc_channel_conditioner dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .channel_index_i     (channel_index_i),
    .raw_value_i         (raw_value_i),
    .fail_safe_i         (fail_safe_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .conditioned_value_o (conditioned_value_o),
    .rising_edge_o       (rising_edge_o),
    .falling_edge_o      (falling_edge_o),
    .zero_span_o         (zero_span_o)
  );

  rcc_result_checker u_result_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .channel_index_i     (channel_index_i),
    .raw_value_i         (raw_value_i),
    .fail_safe_i         (fail_safe_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .conditioned_value_i (conditioned_value_o),
    .rising_edge_i       (rising_edge_o),
    .falling_edge_i      (falling_edge_o),
    .zero_span_i         (zero_span_o),
    .mismatch_count_o    (mismatch_count),
    .results_waiting_o   (results_waiting)
  );

  // Clock with a period of two time units.
  always #1 clk_i = ~clk_i;

  // Writes one register and returns once the transaction has been taken.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0]  data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one sample after a random gap and waits until it is accepted.
  // With no gap, valid simply stays high and the payload changes.
  task automatic send_sample(input logic [CH_BITS-1:0]     ch,
                             input logic [SAMPLE_BITS-1:0] raw,
                             input logic                   failsafe);
    int unsigned gap;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (burst || pick < 10) begin
      gap = 0;
    end else if (pick < 18) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    channel_index_i <= ch;
    raw_value_i     <= raw;
    fail_safe_i     <= failsafe;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stops offering samples and lets every owed result drain, so that the
  // block is idle before the next register write.
  task automatic settle();
    int unsigned guard;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    guard = 0;
    while (results_waiting != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Picks a raw sample, often on or next to a threshold or a calibration bound.
  function automatic logic [SAMPLE_BITS-1:0] pick_raw(input logic [CH_BITS-1:0] ch);
    int          near;
    int unsigned stick;
    stick = ch % STICK_COUNT;
    near  = int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_BITS'(int'(sw_low_cur) + near);
      3:       return SAMPLE_BITS'(int'(sw_high_cur) + near);
      4:       return SAMPLE_BITS'(int'(cal_lo[stick]) + near);
      5:       return SAMPLE_BITS'(int'(cal_hi[stick]) + near);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Chooses and writes the configuration of one random phase. Narrow
  // registers carry noise in the unused upper bits of the write data.
  task automatic setup_phase(input int unsigned p);
    logic signed [VALUE_BITS-1:0] s_lo;
    logic signed [VALUE_BITS-1:0] s_hi;
    logic [STICK_COUNT-1:0]       inv;
    logic [SAMPLE_BITS-1:0]       t;
    logic [CFG_DATA_BITS-1:0]     stray;
    for (int n = 0; n < STICK_COUNT; n++) begin
      cal_lo[n] = SAMPLE_BITS'($urandom_range(0, 700));
      cal_hi[n] = SAMPLE_BITS'($urandom_range(1300, 2047));
      case ($urandom_range(0, 5))
        // Zero span.
        0: cal_hi[n] = cal_lo[n];
        // Reversed calibration.
        1: begin
          t         = cal_lo[n];
          cal_lo[n] = cal_hi[n];
          cal_hi[n] = t;
        end
        default: ;
      endcase
    end
    inv         = STICK_COUNT'($urandom);
    s_lo        = VALUE_BITS'(-$urandom_range(1, 2000));
    s_hi        = VALUE_BITS'($urandom_range(1, 2000));
    sw_low_cur  = THR_BITS'($urandom_range(50, 700));
    sw_high_cur = THR_BITS'($urandom_range(800, 1800));
    case (p)
      // Widest calibration and output scale, every stick inverted.
      0: begin
        for (int n = 0; n < STICK_COUNT; n++) begin
          cal_lo[n] = '0;
          cal_hi[n] = '1;
        end
        s_lo        = 16'sh8000;
        s_hi        = 16'sh7FFF;
        inv         = '1;
        sw_low_cur  = '0;
        sw_high_cur = '1;
      end
      // Crossed output scale.
      2: begin
        s_lo = VALUE_BITS'($urandom_range(0, 3000));
        s_hi = VALUE_BITS'(-$urandom_range(0, 3000));
      end
      // Anything goes, thresholds may cross.
      3: begin
        s_lo        = VALUE_BITS'($urandom);
        s_hi        = VALUE_BITS'($urandom);
        sw_low_cur  = THR_BITS'($urandom);
        sw_high_cur = THR_BITS'($urandom);
      end
      default: ;
    endcase
    stray = CFG_DATA_BITS'({$urandom, $urandom});
    write_reg(CFG_STICK_MIN, {cal_lo[3], cal_lo[2], cal_lo[1], cal_lo[0]});
    write_reg(CFG_STICK_MAX, {cal_hi[3], cal_hi[2], cal_hi[1], cal_hi[0]});
    write_reg(CFG_INVERT, {stray[CFG_DATA_BITS-1:STICK_COUNT], inv});
    write_reg(CFG_SCALE_LOW, {stray[CFG_DATA_BITS-1:VALUE_BITS], s_lo});
    write_reg(CFG_SCALE_HIGH, {stray[CFG_DATA_BITS-1:VALUE_BITS], s_hi});
    write_reg(CFG_SW_LOW, {stray[CFG_DATA_BITS-1:THR_BITS], sw_low_cur});
    write_reg(CFG_SW_HIGH, {~stray[CFG_DATA_BITS-1:THR_BITS], sw_high_cur});
    if (p == 4) begin
      write_reg(CFG_UNUSED, ~stray);
    end
  endtask

  // Receiver: random runs of ready and stall, and a long hold-off on request
  // so that the block fills up and stalls its input.
  initial begin : receiver
    int unsigned run_left;
    int unsigned hold_left;
    int unsigned hold_done;
    logic        run_ready;
    out_ready_i = 1'b0;
    run_left    = 0;
    hold_left   = 0;
    hold_done   = 0;
    run_ready   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_done != hold_wanted) begin
        hold_done++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_ready = ($urandom_range(0, 2) != 0);
          if (run_ready) begin
            run_left = $urandom_range(1, 30);
          end else if ($urandom_range(0, 9) == 0) begin
            run_left = $urandom_range(10, 50);
          end else begin
            run_left = $urandom_range(1, 3);
          end
        end
        run_left--;
        out_ready_i <= run_ready;
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [CH_BITS-1:0] ch;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    channel_index_i = '0;
    raw_value_i     = '0;
    fail_safe_i     = 1'b0;
    burst           = 1'b0;
    hold_wanted     = 0;
    sw_low_cur      = 11'd200;
    sw_high_cur     = 11'd1100;
    for (int n = 0; n < STICK_COUNT; n++) begin
      cal_lo[n] = '0;
      cal_hi[n] = '1;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: stick extremes, failsafe, and both switch kinds
    // across their thresholds, including the middle-zone toggle, and passthrough.
    send_sample(4'd0, 11'd0, 1'b0);
    send_sample(4'd1, 11'd2047, 1'b0);
    send_sample(4'd2, 11'd1023, 1'b0);
    send_sample(4'd3, 11'd777, 1'b1);
    send_sample(4'd4, 11'd2047, 1'b0);
    send_sample(4'd4, 11'd500, 1'b0);
    send_sample(4'd4, 11'd500, 1'b0);
    send_sample(4'd4, 11'd0, 1'b0);
    send_sample(4'd4, 11'd200, 1'b0);
    send_sample(4'd4, 11'd1100, 1'b0);
    send_sample(4'd5, 11'd0, 1'b0);
    send_sample(4'd5, 11'd200, 1'b0);
    send_sample(4'd5, 11'd201, 1'b0);
    send_sample(4'd5, 11'd1101, 1'b0);
    send_sample(4'd15, 11'd2047, 1'b0);
    send_sample(4'd10, 11'd0, 1'b0);
    settle();

    // Full output scale with zero spans on sticks 1 and 3, inversion that
    // saturates, a clamp at the floor and thresholds at their extremes.
    write_reg(CFG_STICK_MIN, {11'd2047, 11'd100, 11'd500, 11'd0});
    write_reg(CFG_STICK_MAX, {11'd2047, 11'd2000, 11'd500, 11'd2047});
    write_reg(CFG_INVERT, {{(CFG_DATA_BITS-STICK_COUNT){1'b0}}, 4'b1011});
    write_reg(CFG_SCALE_LOW, {{(CFG_DATA_BITS-VALUE_BITS){1'b0}}, 16'h8000});
    write_reg(CFG_SCALE_HIGH, {{(CFG_DATA_BITS-VALUE_BITS){1'b0}}, 16'h7FFF});
    write_reg(CFG_SW_LOW, {{(CFG_DATA_BITS-THR_BITS){1'b0}}, 11'd0});
    write_reg(CFG_SW_HIGH, {{(CFG_DATA_BITS-THR_BITS){1'b0}}, 11'd2047});
    send_sample(4'd0, 11'd0, 1'b0);
    send_sample(4'd0, 11'd2047, 1'b0);
    send_sample(4'd1, 11'd5, 1'b0);
    send_sample(4'd3, 11'd9, 1'b1);
    send_sample(4'd2, 11'd50, 1'b0);
    send_sample(4'd4, 11'd0, 1'b0);
    send_sample(4'd8, 11'd2047, 1'b0);
    send_sample(4'd9, 11'd2047, 1'b0);
    settle();

    // Crossed scale: the clamp must settle on the floor.
    write_reg(CFG_STICK_MIN, '0);
    write_reg(CFG_STICK_MAX, '1);
    write_reg(CFG_INVERT, '0);
    write_reg(CFG_SCALE_LOW, {{(CFG_DATA_BITS-VALUE_BITS){1'b0}}, 16'sd100});
    write_reg(CFG_SCALE_HIGH, {{(CFG_DATA_BITS-VALUE_BITS){1'b0}}, -16'sd100});
    send_sample(4'd0, 11'd1000, 1'b0);
    settle();

    // Random phases, each under its own configuration.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      setup_phase(p);
      if (p == 2) begin
        hold_wanted++;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) begin
          burst = ($urandom_range(0, 3) == 0);
        end
        ch = CH_BITS'($urandom_range(0, CHANNEL_COUNT - 1));
        send_sample(ch, pick_raw(ch), $urandom_range(0, 9) == 0);
      end
      burst = 1'b0;
      settle();
    end

    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("status: pass");
    end else begin
      if (results_waiting != 0) begin
        $error("%0d predicted results never arrived", results_waiting);
      end
      $display("status: fail");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin : watchdog
    #1_200_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
